// ----- sv/ppmfs_pkg.sv -----
// ppmfs_pkg: shared types and constants for the ppm frame sequencer
// used by every module under sv/ except ppmfs_chan_store; no dependencies of its own

package ppmfs_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_NUM_CHANNELS  = 3'd0,
        REG_PPM_DISABLE   = 3'd1,
        REG_PWM_DISABLE   = 3'd2,
        REG_PULSE_LEN     = 3'd3,
        REG_FRAME_LEN     = 3'd4,
        REG_SYNC_FLOOR_US = 3'd5,
        REG_TICK_SCALE    = 3'd6
    } reg_idx_t;

    localparam logic [4:0]  RST_NUM_CHANNELS  = 5'd8;
    localparam logic        RST_PPM_DISABLE   = 1'b0;
    localparam logic        RST_PWM_DISABLE   = 1'b1;
    localparam logic [15:0] RST_PULSE_LEN     = 16'd600;
    localparam logic [15:0] RST_FRAME_LEN     = 16'd40000;
    localparam logic [14:0] RST_SYNC_FLOOR_US = 15'd3000;
    localparam logic [1:0]  RST_TICK_SCALE    = 2'd2;

    // channel slots from this index up never carry a pulse
    localparam int PULSED_CHANNELS = 8;

    localparam logic [15:0] NO_PULSE = 16'd65535;

    // piecewise raw value to microseconds map
    localparam logic [15:0] MAP_LOW_LIMIT  = 16'd12;
    localparam logic [15:0] MAP_MID_LIMIT  = 16'd1012;
    localparam logic [15:0] MAP_HIGH_LIMIT = 16'd1024;
    localparam logic [11:0] MAP_LOW_BASE   = 12'd808;
    localparam logic [11:0] MAP_MID_OFFSET = 12'd988;
    localparam logic [9:0]  MAP_HIGH_REF   = 10'd1011;
    localparam logic [11:0] MAP_HIGH_BASE  = 12'd2000;
    localparam logic [11:0] MAP_TOP        = 12'd2192;

    typedef struct packed {
        logic [4:0]  num_channels;
        logic        ppm_disable;
        logic        pwm_disable;
        logic [15:0] pulse_len;
        logic [15:0] frame_len;
        logic [14:0] sync_floor_us;
        logic [1:0]  tick_scale;
    } cfg_t;

    // what one period-end item produces: next state and result fields
    typedef struct packed {
        logic [4:0]  slot_counter;
        logic [15:0] next_period;
        logic [16:0] sync_remaining;
        logic [15:0] compare;
        logic        is_sync;
        logic        pwm_update;
        logic [3:0]  pwm_channel;
    } calc_t;

endpackage

// ----- sv/ppm_frame_sequencer.sv -----
// ppm_frame_sequencer: top level, input register, slot state and result register
// depends on ppmfs_pkg, ppmfs_cfg_regs, ppmfs_chan_store, ppmfs_slot_calc
//
//  channel   handshake                  payload
//  item      item_valid / item_stall    action, channel_index, channel_value
//  result    result_valid / result_stall period_ticks, compare_ticks, slot_index,
//                                        is_sync, pwm_update, pwm_channel
//  config    apb psel/penable/pready    paddr, pwdata, prdata
//
// one item per clock while item_stall is low; a result passes from its item
// through the input register and then the result register.
// a store item gives no result and always completes in its cycle.
// while the result register holds an unaccepted result, a period-end item
// waits in the input register and item_stall is raised.
// reset sets the registers to defaults, clears the channel values and the slot state.

module ppm_frame_sequencer #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppmfs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppmfs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppmfs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              action,
    input  logic [3:0]                        channel_index,
    input  logic [15:0]                       channel_value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [15:0]                       period_ticks,
    output logic [15:0]                       compare_ticks,
    output logic [4:0]                        slot_index,
    output logic                              is_sync,
    output logic                              pwm_update,
    output logic [3:0]                        pwm_channel
);

    ppmfs_pkg::cfg_t  cfg;
    ppmfs_pkg::calc_t calc;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [3:0]  s1_index_reg;
    logic [15:0] s1_value_reg;
    logic        s1_fire;
    logic        s1_period;
    logic        item_take;

    logic [4:0]  slot_counter_reg;
    logic [15:0] next_period_reg;
    logic [16:0] sync_remaining_reg;
    logic [15:0] raw_value;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_period_reg;
    logic [15:0] out_compare_reg;
    logic [4:0]  out_slot_reg;
    logic        out_sync_reg;
    logic        out_pwm_update_reg;
    logic [3:0]  out_pwm_channel_reg;

    ppmfs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppmfs_chan_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (s1_valid_reg && !s1_action_reg),
        .wr_index   (s1_index_reg),
        .wr_value   (s1_value_reg),
        .rd_counter (slot_counter_reg),
        .rd_value   (raw_value)
    );

    ppmfs_slot_calc #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_calc (
        .cfg            (cfg),
        .cur            (slot_counter_reg),
        .raw_value      (raw_value),
        .sync_remaining (sync_remaining_reg),
        .calc           (calc)
    );

    // a period item moves on once the result register is free or being drained
    assign s1_period  = s1_valid_reg && s1_action_reg;
    assign s1_fire    = s1_valid_reg && (!s1_action_reg || !out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_fire;
    assign item_take  = item_valid && !item_stall;

    assign out_valid_next = (s1_fire && s1_action_reg) || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_action_reg <= action;
            s1_index_reg  <= channel_index;
            s1_value_reg  <= channel_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_counter_reg   <= 5'd0;
            next_period_reg    <= ppmfs_pkg::RST_FRAME_LEN;
            sync_remaining_reg <= {1'b0, ppmfs_pkg::RST_FRAME_LEN};
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_fire && s1_action_reg)
            begin
                slot_counter_reg   <= calc.slot_counter;
                next_period_reg    <= calc.next_period;
                sync_remaining_reg <= calc.sync_remaining;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_action_reg)
        begin
            out_period_reg      <= next_period_reg;
            out_compare_reg     <= calc.compare;
            out_slot_reg        <= slot_counter_reg;
            out_sync_reg        <= calc.is_sync;
            out_pwm_update_reg  <= calc.pwm_update;
            out_pwm_channel_reg <= calc.pwm_channel;
        end
    end

    assign result_valid  = out_valid_reg;
    assign period_ticks  = out_period_reg;
    assign compare_ticks = out_compare_reg;
    assign slot_index    = out_slot_reg;
    assign is_sync       = out_sync_reg;
    assign pwm_update    = out_pwm_update_reg;
    assign pwm_channel   = out_pwm_channel_reg;

`ifndef SYNTHESIS
    // the slot counter never runs past the channel count
    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_counter_reg) <= MAX_CHANNELS)
        else $error("slot counter past channel count");

    // a fresh result only comes from a period item leaving the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_period && s1_fire))
        else $error("result without period item");

    // the reported period is the one computed at the previous event
    a_period_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_period && s1_fire) |=> (out_period_reg == $past(next_period_reg)))
        else $error("reported period mismatch");

    // a sync slot restarts the frame
    a_sync_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_period && s1_fire && calc.is_sync) |=> (slot_counter_reg == 5'd0))
        else $error("frame did not restart after sync");
`endif

endmodule

// ----- sv/ppmfs_cfg_regs.sv -----
// ppmfs_cfg_regs: apb register file for the sequencer settings
// depends on ppmfs_pkg (register map, reset values, cfg_t)

module ppmfs_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppmfs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppmfs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppmfs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output ppmfs_pkg::cfg_t                   cfg
);

    ppmfs_pkg::cfg_t   cfg_reg;
    ppmfs_pkg::cfg_t   cfg_next;
    ppmfs_pkg::reg_idx_t reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = ppmfs_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                ppmfs_pkg::REG_NUM_CHANNELS:  cfg_next.num_channels  = pwdata[4:0];
                ppmfs_pkg::REG_PPM_DISABLE:   cfg_next.ppm_disable   = pwdata[0];
                ppmfs_pkg::REG_PWM_DISABLE:   cfg_next.pwm_disable   = pwdata[0];
                ppmfs_pkg::REG_PULSE_LEN:     cfg_next.pulse_len     = pwdata[15:0];
                ppmfs_pkg::REG_FRAME_LEN:     cfg_next.frame_len     = pwdata[15:0];
                ppmfs_pkg::REG_SYNC_FLOOR_US: cfg_next.sync_floor_us = pwdata[14:0];
                ppmfs_pkg::REG_TICK_SCALE:    cfg_next.tick_scale    = pwdata[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            ppmfs_pkg::REG_NUM_CHANNELS:  prdata = {27'd0, cfg_reg.num_channels};
            ppmfs_pkg::REG_PPM_DISABLE:   prdata = {31'd0, cfg_reg.ppm_disable};
            ppmfs_pkg::REG_PWM_DISABLE:   prdata = {31'd0, cfg_reg.pwm_disable};
            ppmfs_pkg::REG_PULSE_LEN:     prdata = {16'd0, cfg_reg.pulse_len};
            ppmfs_pkg::REG_FRAME_LEN:     prdata = {16'd0, cfg_reg.frame_len};
            ppmfs_pkg::REG_SYNC_FLOOR_US: prdata = {17'd0, cfg_reg.sync_floor_us};
            ppmfs_pkg::REG_TICK_SCALE:    prdata = {30'd0, cfg_reg.tick_scale};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels  <= ppmfs_pkg::RST_NUM_CHANNELS;
            cfg_reg.ppm_disable   <= ppmfs_pkg::RST_PPM_DISABLE;
            cfg_reg.pwm_disable   <= ppmfs_pkg::RST_PWM_DISABLE;
            cfg_reg.pulse_len     <= ppmfs_pkg::RST_PULSE_LEN;
            cfg_reg.frame_len     <= ppmfs_pkg::RST_FRAME_LEN;
            cfg_reg.sync_floor_us <= ppmfs_pkg::RST_SYNC_FLOOR_US;
            cfg_reg.tick_scale    <= ppmfs_pkg::RST_TICK_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/ppmfs_chan_store.sv -----
// ppmfs_chan_store: raw value per channel, one write port and one read port
// depends on nothing but its parameter; entries reset to zero

module ppmfs_chan_store #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [3:0]  wr_index,
    input  logic [15:0] wr_value,
    input  logic [4:0]  rd_counter,
    output logic [15:0] rd_value
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [15:0]        value_reg [MAX_CHANNELS];
    logic [IDX_W+3:0]   wr_wide;
    logic [IDX_W+4:0]   rd_wide;
    logic [IDX_W-1:0]   wr_slot;
    logic [IDX_W-1:0]   rd_slot;
    logic               wr_in_range;

    assign wr_wide     = {{IDX_W{1'b0}}, wr_index};
    assign rd_wide     = {{IDX_W{1'b0}}, rd_counter};
    assign wr_slot     = wr_wide[IDX_W-1:0];
    assign rd_slot     = rd_wide[IDX_W-1:0];
    // indexes past the channel count are dropped
    assign wr_in_range = 32'(wr_index) < MAX_CHANNELS;
    assign rd_value    = value_reg[rd_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                value_reg[i] <= '0;
            end
        end
        else if (wr_en && wr_in_range)
        begin
            value_reg[wr_slot] <= wr_value;
        end
    end

endmodule

// ----- sv/ppmfs_slot_calc.sv -----
// ppmfs_slot_calc: next slot period, compare point, sync bookkeeping and pwm select
// depends on ppmfs_pkg (cfg_t, calc_t, map constants); purely combinational

module ppmfs_slot_calc #(
    parameter int MAX_CHANNELS = 16
) (
    input  ppmfs_pkg::cfg_t  cfg,
    input  logic [4:0]       cur,
    input  logic [15:0]      raw_value,
    input  logic [16:0]      sync_remaining,
    output ppmfs_pkg::calc_t calc
);

    localparam logic [5:0] MAX_CH6 = 6'(MAX_CHANNELS);

    logic [5:0]  eff_count;
    logic        is_channel;
    logic [9:0]  high_off;
    logic [11:0] us_val;
    logic [15:0] slot;
    logic [16:0] floor_val;
    logic [17:0] rem;
    logic        below_floor;
    logic [15:0] sync_period;
    logic [15:0] cmp_period;
    logic [15:0] cmp_val;
    logic        pulsed;

    assign eff_count  = ({1'b0, cfg.num_channels} > MAX_CH6) ? MAX_CH6
                                                             : {1'b0, cfg.num_channels};
    assign is_channel = {1'b0, cur} < eff_count;
    assign high_off   = raw_value[9:0] - ppmfs_pkg::MAP_HIGH_REF;

    always_comb
    begin
        if (raw_value < ppmfs_pkg::MAP_LOW_LIMIT)
            us_val = ppmfs_pkg::MAP_LOW_BASE + {4'd0, raw_value[3:0], 4'd0};
        else if (raw_value < ppmfs_pkg::MAP_MID_LIMIT)
            us_val = ppmfs_pkg::MAP_MID_OFFSET + {2'd0, raw_value[9:0]};
        else if (raw_value < ppmfs_pkg::MAP_HIGH_LIMIT)
            us_val = ppmfs_pkg::MAP_HIGH_BASE + {4'd0, high_off[3:0], 4'd0};
        else
            us_val = ppmfs_pkg::MAP_TOP;
    end

    assign slot      = 16'(us_val * cfg.tick_scale);
    assign floor_val = 17'(cfg.sync_floor_us * cfg.tick_scale);

    // signed remainder; sign bit set means it went below zero
    assign rem         = {1'b0, sync_remaining} - {2'b00, slot};
    assign below_floor = rem[17] || (rem[16:0] < floor_val);

    assign sync_period = sync_remaining[16] ? 16'hFFFF : sync_remaining[15:0];
    assign cmp_period  = is_channel ? slot : sync_period;
    assign cmp_val     = (cmp_period < cfg.pulse_len) ? 16'd0 : cmp_period - cfg.pulse_len;
    assign pulsed      = !is_channel || (32'(cur) < ppmfs_pkg::PULSED_CHANNELS);

    always_comb
    begin
        calc.compare = (cfg.ppm_disable || !pulsed) ? ppmfs_pkg::NO_PULSE : cmp_val;
        calc.is_sync = !is_channel;
        if (is_channel)
        begin
            calc.slot_counter   = cur + 5'd1;
            calc.next_period    = slot;
            calc.sync_remaining = below_floor ? floor_val : rem[16:0];
        end
        else
        begin
            calc.slot_counter   = 5'd0;
            calc.next_period    = sync_period;
            calc.sync_remaining = {1'b0, cfg.frame_len};
        end
        // first slot of the frame leaves the pwm outputs alone
        if (!cfg.pwm_disable && (cur != 5'd0))
        begin
            calc.pwm_update  = 1'b1;
            calc.pwm_channel = 4'(cur - 5'd1);
        end
        else
        begin
            calc.pwm_update  = 1'b0;
            calc.pwm_channel = 4'd0;
        end
    end

endmodule
